// File: src/buddy_memory_allocator_defines.svh
// ----------------------------------------------------------------------------
// Buddy allocator assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BUDDY_MEMORY_ALLOCATOR_DEFINES_SVH
`define BUDDY_MEMORY_ALLOCATOR_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define BMA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("buddy allocator check failed");

// Check a consequence in the cycle after its antecedent.
`define BMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("buddy allocator check failed");

`endif

// File: src/bma_pkg.sv
// ----------------------------------------------------------------------------
// Buddy allocator package
// Request and result types, status and opcode codes, sequencer states, ceil-log2 helper.
// ----------------------------------------------------------------------------
package bma_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_NO_SPACE   = 2'd1,
    STS_UNKNOWN_ID = 2'd2,
    STS_IDS_GONE   = 2'd3
  } status_t;

  typedef struct packed {
    logic        opcode;
    logic [15:0] request_size;
    logic [7:0]  block_id;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  given_id;
    logic [9:0]  block_address;
    logic [3:0]  block_order;
    logic [9:0]  fragmentation_total;
  } res_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_INIT, ST_IDLE, ST_ALLOC, ST_SCAN, ST_SCAN_CHK, ST_SPLIT,
    ST_FINISH, ST_FREE, ST_FREE_CHK, ST_MRG_RD, ST_MRG_CHK, ST_FREE_SET, ST_DONE
  } state_t;

  // smallest k with 2^k >= size (zero and one give zero)
  function automatic logic [4:0] ceil_log2_16(input logic [15:0] size);
    logic [15:0] sm1;
    logic [4:0]  k;
    sm1 = size - 16'd1;
    k   = 5'd0;
    if (size > 16'd1) begin
      for (int b = 0; b < 16; b++) begin
        if (sm1[b]) k = 5'(b + 1);
      end
    end
    return k;
  endfunction

endpackage

// File: src/buddy_memory_allocator.sv
// ----------------------------------------------------------------------------
// Buddy memory allocator
// Allocate: scan the free map from the requested order up, take the first
// free block and split it down to size. Free: merge with each free buddy, an
// order at a time, until a busy buddy or the top. One request at a time; the
// free map's single read port sets the pace. Reset and every max_order write
// run a clearing pass over the free map before the next request is taken.
// ----------------------------------------------------------------------------
module buddy_memory_allocator #(
  parameter int MEM_ORDER = 10,
  parameter int NUM_IDS   = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [3:0]    cfg_data,
  input  logic          req_valid,
  output logic          req_stall,
  input  bma_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_stall,
  output bma_pkg::res_t res
);
  import bma_pkg::*;
  `include "buddy_memory_allocator_defines.svh"

  // widths derived from the parameters
  localparam int AW     = MEM_ORDER;
  localparam int AW1    = AW + 1;
  localparam int ORD_W  = $clog2(MEM_ORDER + 1);
  localparam int NODE_W = MEM_ORDER + 1;
  localparam int ID_W   = $clog2(NUM_IDS);
  localparam int NID_W  = $clog2(NUM_IDS + 1);
  localparam int RQ_W   = MEM_ORDER + 1;
  localparam int TB_W   = 1 + AW + ORD_W + RQ_W;
  localparam int RESET_ORDER = (10 > MEM_ORDER) ? MEM_ORDER : 10;

  // table entry layout: {valid, address, order, requested size}
  localparam int TB_V  = TB_W - 1;
  localparam int TB_AL = ORD_W + RQ_W;
  localparam int TB_OL = RQ_W;

  // free map: one bit per (order, aligned address) node
  logic              fm [2**NODE_W];
  logic              fm_we, fm_wdata, fm_rdata;
  logic [NODE_W-1:0] fm_waddr, fm_raddr;

  // block table, indexed by id; ids at or above next_id read as invalid
  logic [TB_W-1:0]   tb [NUM_IDS];
  logic              tb_we;
  logic [ID_W-1:0]   tb_waddr, tb_raddr;
  logic [TB_W-1:0]   tb_wdata, tb_rdata;

  state_t            state, state_next;
  logic [ORD_W-1:0]  max_order, max_order_next;
  logic [NID_W-1:0]  next_id, next_id_next;
  logic [AW-1:0]     waste, waste_next;
  logic [NODE_W-1:0] clr, clr_next;
  logic [15:0]       size, size_next;
  logic [7:0]        id, id_next;
  logic [4:0]        k, k_next;
  logic [ORD_W-1:0]  lvl, lvl_next;
  logic [AW-1:0]     a, a_next;
  res_t              rslt, rslt_next;
  res_t              res_next;
  logic              res_valid_next;

  // per-entry views of the table read data
  logic              ent_v;
  logic [AW-1:0]     ent_a;
  logic [ORD_W-1:0]  ent_o;
  logic [RQ_W-1:0]   ent_r;
  logic [AW-1:0]     bud_bit;
  logic              lvl_end;

  assign ent_v = tb_rdata[TB_V];
  assign ent_a = tb_rdata[TB_AL +: AW];
  assign ent_o = tb_rdata[TB_OL +: ORD_W];
  assign ent_r = tb_rdata[0 +: RQ_W];

  function automatic logic [NODE_W-1:0] node_of(input logic [ORD_W-1:0] ord,
                                                input logic [AW-1:0] adr);
    return (NODE_W'(1) << (MEM_ORDER - int'(ord))) + NODE_W'(adr >> ord);
  endfunction

  assign bud_bit = AW'(1) << lvl;
  // last node of this order inside the managed memory
  assign lvl_end = ({1'b0, a} + (AW1'(1) << lvl)) == (AW1'(1) << max_order);

  assign req_stall = (state != ST_IDLE);

  // memories
  always_ff @(posedge clk) begin
    if (fm_we) fm[fm_waddr] <= fm_wdata;
    fm_rdata <= fm[fm_raddr];
  end

  always_ff @(posedge clk) begin
    if (tb_we) tb[tb_waddr] <= tb_wdata;
    tb_rdata <= tb[tb_raddr];
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      max_order <= ORD_W'(RESET_ORDER);
      next_id   <= NID_W'(1);
      waste     <= '0;
      clr       <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      max_order <= max_order_next;
      next_id   <= next_id_next;
      waste     <= waste_next;
      clr       <= clr_next;
      res_valid <= res_valid_next;
    end
  end

  // request payload and working registers
  always_ff @(posedge clk) begin
    size <= size_next;
    id   <= id_next;
    k    <= k_next;
    lvl  <= lvl_next;
    a    <= a_next;
    rslt <= rslt_next;
    res  <= res_next;
  end

  // sequencer
  always_comb begin
    state_next     = state;
    max_order_next = max_order;
    next_id_next   = next_id;
    waste_next     = waste;
    clr_next       = clr;
    size_next      = size;
    id_next        = id;
    k_next         = k;
    lvl_next       = lvl;
    a_next         = a;
    rslt_next      = rslt;
    res_next       = res;
    res_valid_next = res_valid && res_stall;
    fm_we          = 1'b0;
    fm_waddr       = '0;
    fm_wdata       = 1'b0;
    fm_raddr       = '0;
    tb_we          = 1'b0;
    tb_waddr       = ID_W'(id);
    tb_wdata       = tb_rdata;
    tb_raddr       = ID_W'(id);

    // failure result template: fields zero, current fragmentation total
    case (state)
      ST_CLEAR: begin
        // sweep the free map to all-allocated
        fm_we    = 1'b1;
        fm_waddr = clr;
        clr_next = clr + NODE_W'(1);
        if (&clr) state_next = ST_INIT;
      end
      ST_INIT: begin
        // free the top block
        fm_we      = 1'b1;
        fm_waddr   = node_of(max_order, '0);
        fm_wdata   = 1'b1;
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          size_next  = req.request_size;
          id_next    = req.block_id;
          k_next     = ceil_log2_16(req.request_size);
          state_next = (req.opcode == OP_ALLOC) ? ST_ALLOC : ST_FREE;
        end
      end
      ST_ALLOC: begin
        rslt_next = '{status: STS_OK, given_id: '0, block_address: '0,
                      block_order: '0, fragmentation_total: 10'(waste)};
        if (32'(next_id) >= NUM_IDS) begin
          rslt_next.status = STS_IDS_GONE;
          state_next       = ST_DONE;
        end else if (32'(k) > 32'(max_order)) begin
          rslt_next.status = STS_NO_SPACE;
          state_next       = ST_DONE;
        end else begin
          lvl_next   = ORD_W'(k);
          a_next     = '0;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        fm_raddr   = node_of(lvl, a);
        state_next = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (fm_rdata) begin
          // take this block off the free map
          fm_we      = 1'b1;
          fm_waddr   = node_of(lvl, a);
          state_next = ST_SPLIT;
        end else if (lvl_end) begin
          if (lvl == max_order) begin
            rslt_next.status = STS_NO_SPACE;
            state_next       = ST_DONE;
          end else begin
            lvl_next   = lvl + ORD_W'(1);
            a_next     = '0;
            state_next = ST_SCAN;
          end
        end else begin
          a_next     = a + bud_bit;
          state_next = ST_SCAN;
        end
      end
      ST_SPLIT: begin
        // halve the block, free the upper half
        if (32'(lvl) > 32'(k)) begin
          fm_we      = 1'b1;
          fm_waddr   = node_of(lvl - ORD_W'(1), a | (AW'(1) << (lvl - ORD_W'(1))));
          fm_wdata   = 1'b1;
          lvl_next   = lvl - ORD_W'(1);
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        waste_next = waste + AW'((AW1'(1) << k) - AW1'(size));
        tb_we      = 1'b1;
        tb_waddr   = ID_W'(next_id);
        tb_wdata   = {1'b1, a, ORD_W'(k), RQ_W'(size)};
        rslt_next  = '{status: STS_OK, given_id: 8'(next_id), block_address: 10'(a),
                       block_order: 4'(k), fragmentation_total: 10'(waste_next)};
        next_id_next = next_id + NID_W'(1);
        state_next   = ST_DONE;
      end
      ST_FREE: begin
        rslt_next = '{status: STS_UNKNOWN_ID, given_id: '0, block_address: '0,
                      block_order: '0, fragmentation_total: 10'(waste)};
        if (id == 8'd0 || 32'(id) >= NUM_IDS || 32'(id) >= 32'(next_id)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_FREE_CHK;
        end
      end
      ST_FREE_CHK: begin
        if (!ent_v) begin
          state_next = ST_DONE;
        end else begin
          // release the entry and drop its waste
          tb_we      = 1'b1;
          tb_wdata   = {1'b0, ent_a, ent_o, ent_r};
          waste_next = waste - AW'((AW1'(1) << ent_o) - AW1'(ent_r));
          a_next     = ent_a;
          lvl_next   = ent_o;
          state_next = ST_MRG_RD;
        end
      end
      ST_MRG_RD: begin
        if (lvl < max_order) begin
          fm_raddr   = node_of(lvl, a ^ bud_bit);
          state_next = ST_MRG_CHK;
        end else begin
          state_next = ST_FREE_SET;
        end
      end
      ST_MRG_CHK: begin
        if (fm_rdata) begin
          // absorb the free buddy, move one order up
          fm_we      = 1'b1;
          fm_waddr   = node_of(lvl, a ^ bud_bit);
          a_next     = a & ~bud_bit;
          lvl_next   = lvl + ORD_W'(1);
          state_next = ST_MRG_RD;
        end else begin
          state_next = ST_FREE_SET;
        end
      end
      ST_FREE_SET: begin
        fm_we      = 1'b1;
        fm_waddr   = node_of(lvl, a);
        fm_wdata   = 1'b1;
        rslt_next  = '{status: STS_OK, given_id: '0, block_address: 10'(a),
                       block_order: 4'(lvl), fragmentation_total: 10'(waste)};
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!res_valid || !res_stall) begin
          res_next       = rslt;
          res_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase

    // a register write sets max_order and restarts ids, waste and the free-map clear
    if (cfg_we) begin
      max_order_next = (32'(cfg_data) > MEM_ORDER) ? ORD_W'(MEM_ORDER) : ORD_W'(cfg_data);
      next_id_next   = NID_W'(1);
      waste_next     = '0;
      clr_next       = '0;
      state_next     = ST_CLEAR;
    end
  end

  `BMA_ASSERT_NEXT(a_cfg_clears, cfg_we, state == ST_CLEAR)
  `BMA_ASSERT_NEXT(a_req_leaves_idle, req_valid && !req_stall, state != ST_IDLE)
  `BMA_ASSERT_NOW(a_id_bound, 1'b1, 32'(next_id) <= NUM_IDS && next_id != '0)

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator testbench
// Drives allocate and free requests through the valid/stall handshake, keeps
// its own copy of the free map, id table and waste total, and checks every
// result against it. Covers several max_order settings and random idling.
// ----------------------------------------------------------------------------
module tb_top;
  import bma_pkg::*;

  localparam int MEM_ORDER = 10;
  localparam int NUM_IDS   = 256;
  localparam int MAP_DEPTH = 2 << MEM_ORDER;
  // Worst allocate scans the whole free map and then splits, before any stalls.
  localparam longint CYCLE_LIMIT = 40_000_000;

  logic  clk;
  logic  rst;
  logic  cfg_we;
  logic  [3:0] cfg_data;
  logic  req_valid;
  logic  req_stall;
  req_t  req;
  logic  res_valid;
  logic  res_stall;
  res_t  res;

  buddy_memory_allocator #(
    .MEM_ORDER(MEM_ORDER),
    .NUM_IDS  (NUM_IDS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

  // Shadow allocator state
  bit          shadow_map [MAP_DEPTH];
  bit          id_live    [NUM_IDS];
  int unsigned id_addr    [NUM_IDS];
  int unsigned id_order   [NUM_IDS];
  int unsigned id_req     [NUM_IDS];
  int unsigned issue_id;
  int unsigned waste_sum;
  int unsigned mem_order;

  req_t pending_requests[$];
  res_t expected_results[$];

  int  src_idle_pct;
  int  snk_idle_pct;
  int  mismatches;
  int  checked;
  int  n_ok, n_nospace, n_unknown, n_idsgone;
  longint cycles;

  function automatic int unsigned map_node(int unsigned ord, int unsigned addr);
    return (1 << (MEM_ORDER - ord)) + ((addr & ((1 << MEM_ORDER) - 1)) >> ord);
  endfunction

  // Saturate the order, clear the map, the table and the counters, free the top block.
  function automatic void shadow_reinit(logic [3:0] value);
    mem_order = (value > MEM_ORDER) ? MEM_ORDER : value;
    foreach (shadow_map[n]) shadow_map[n] = 1'b0;
    foreach (id_live[n]) id_live[n] = 1'b0;
    issue_id  = 1;
    waste_sum = 0;
    shadow_map[map_node(mem_order, 0)] = 1'b1;
  endfunction

  // Apply one request to the shadow state and return its result.
  function automatic res_t buddy_outcome(req_t r);
    res_t        o;
    int unsigned k, i, j, a, b, ord, sz;
    bit          found;
    o        = '0;
    o.status = STS_OK;
    sz       = r.request_size;
    if (r.opcode == OP_ALLOC) begin
      k = 0;
      while ((1 << k) < sz && k < 16) k++;
      if (issue_id >= NUM_IDS) begin
        o.status = STS_IDS_GONE;
      end else if (k > mem_order) begin
        o.status = STS_NO_SPACE;
      end else begin
        found = 1'b0;
        a     = 0;
        i     = k;
        while (i <= mem_order && !found) begin
          for (j = 0; j < (1 << (mem_order - i)) && !found; j++) begin
            if (shadow_map[map_node(i, j << i)]) begin
              a     = j << i;
              found = 1'b1;
            end
          end
          if (!found) i++;
        end
        if (!found) begin
          o.status = STS_NO_SPACE;
        end else begin
          shadow_map[map_node(i, a)] = 1'b0;
          while (i > k) begin
            i--;
            shadow_map[map_node(i, a + (1 << i))] = 1'b1;
          end
          waste_sum          += (1 << k) - sz;
          id_live[issue_id]   = 1'b1;
          id_addr[issue_id]   = a;
          id_order[issue_id]  = k;
          id_req[issue_id]    = sz;
          o.given_id          = issue_id[7:0];
          o.block_address     = a[9:0];
          o.block_order       = k[3:0];
          issue_id++;
        end
      end
    end else begin
      if (r.block_id == 0 || r.block_id >= NUM_IDS || !id_live[r.block_id]) begin
        o.status = STS_UNKNOWN_ID;
      end else begin
        a   = id_addr[r.block_id];
        ord = id_order[r.block_id];
        id_live[r.block_id] = 1'b0;
        waste_sum -= (1 << ord) - id_req[r.block_id];
        // Climb while the buddy at this order is free.
        while (ord < mem_order && shadow_map[map_node(ord, a ^ (1 << ord))]) begin
          b = a ^ (1 << ord);
          shadow_map[map_node(ord, b)] = 1'b0;
          if (b < a) a = b;
          ord++;
        end
        shadow_map[map_node(ord, a)] = 1'b1;
        o.block_address = a[9:0];
        o.block_order   = ord[3:0];
      end
    end
    o.fragmentation_total = waste_sum[9:0];
    return o;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Driver: present queued requests, predict each one as it is taken.
  always @(posedge clk) begin
    logic next_valid;
    req_t next_req;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      next_valid = req_valid;
      next_req   = req;
      if (req_valid && !req_stall) begin
        expected_results.push_back(buddy_outcome(req));
        next_valid = 1'b0;
      end
      // Hold off at random before presenting the next request.
      if (!next_valid && pending_requests.size() > 0 &&
          $urandom_range(99) >= src_idle_pct) begin
        next_req   = pending_requests.pop_front();
        next_valid = 1'b1;
      end
      req_valid <= next_valid;
      req       <= next_req;
    end
  end

  // Monitor: stall at random, compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing outstanding: got %p", $time, res);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          checked++;
          case (want.status)
            STS_OK:         n_ok++;
            STS_NO_SPACE:   n_nospace++;
            STS_UNKNOWN_ID: n_unknown++;
            default:        n_idsgone++;
          endcase
          if (res.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, res.status);
            mismatches++;
          end
          if (res.given_id !== want.given_id) begin
            $display("%0t: given_id expected %0d got %0d", $time, want.given_id,
                     res.given_id);
            mismatches++;
          end
          if (res.block_address !== want.block_address) begin
            $display("%0t: block_address expected %0d got %0d", $time,
                     want.block_address, res.block_address);
            mismatches++;
          end
          if (res.block_order !== want.block_order) begin
            $display("%0t: block_order expected %0d got %0d", $time, want.block_order,
                     res.block_order);
            mismatches++;
          end
          if (res.fragmentation_total !== want.fragmentation_total) begin
            $display("%0t: fragmentation_total expected %0d got %0d", $time,
                     want.fragmentation_total, res.fragmentation_total);
            mismatches++;
          end
        end
      end
      res_stall <= ($urandom_range(99) < snk_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time,
               expected_results.size());
      $display("buddy_memory_allocator: mismatch");
      $finish;
    end
  end

  // Queue one request once the previous one has been taken, so that frees
  // can be aimed at ids that are live at that moment.
  task automatic send_request(input logic op, input logic [15:0] sz, input logic [7:0] id);
    req_t r;
    do @(posedge clk); while (pending_requests.size() != 0 || req_valid);
    r.opcode       = op;
    r.request_size = sz;
    r.block_id     = id;
    pending_requests.push_back(r);
  endtask

  task automatic drain;
    do @(posedge clk);
    while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_max_order(input logic [3:0] value);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    shadow_reinit(value);
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Mostly well-formed traffic: allocations sized to the current memory and
  // frees of live ids, with some oversized, zero, full-width and stray-id noise.
  task automatic random_traffic(input int count, input int total, inout int done);
    int          pick, ord, live_n;
    int unsigned live[$];
    logic [15:0] sz;
    logic [7:0]  id;
    for (int n = 0; n < count; n++) begin
      case (done * 3 / total)
        0:       begin src_idle_pct = 30; snk_idle_pct = 66; end
        1:       begin src_idle_pct = 66; snk_idle_pct = 30; end
        default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
      endcase
      done++;
      live.delete();
      foreach (id_live[i]) if (id_live[i]) live.push_back(i);
      live_n = live.size();
      pick   = $urandom_range(99);
      if (pick < 45 || (pick < 88 && live_n == 0)) begin
        ord = $urandom_range(mem_order);
        sz  = (ord == 0) ? 16'd1 : 16'($urandom_range(1 << ord, (1 << (ord - 1)) + 1));
        if ($urandom_range(19) == 0) sz = 16'd0;
        send_request(OP_ALLOC, sz, 8'($urandom));
      end else if (pick < 88) begin
        id = 8'(live[$urandom_range(live_n - 1)]);
        send_request(OP_FREE, 16'($urandom), id);
      end else if (pick < 94) begin
        send_request(OP_ALLOC, 16'($urandom), 8'($urandom));
      end else begin
        send_request(OP_FREE, 16'($urandom), 8'($urandom));
      end
    end
  endtask

  // Stimulus
  initial begin
    int          done;
    int          total;
    logic [3:0]  orders[$];
    int          counts[$];
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    req_valid    = 1'b0;
    req          = '0;
    res_stall    = 1'b0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    shadow_reinit(4'd10);
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: size extremes, stray ids, splitting and full merge back to the top.
    src_idle_pct = 30;
    snk_idle_pct = 66;
    send_request(OP_ALLOC, 16'd0,     8'd0);
    send_request(OP_ALLOC, 16'd1,     8'd0);
    send_request(OP_ALLOC, 16'd1024,  8'd0);
    send_request(OP_ALLOC, 16'd1025,  8'd0);
    send_request(OP_ALLOC, 16'hFFFF,  8'hFF);
    send_request(OP_ALLOC, 16'd512,   8'd0);
    send_request(OP_ALLOC, 16'd3,     8'd0);
    send_request(OP_FREE,  16'd0,     8'd0);
    send_request(OP_FREE,  16'd0,     8'd255);
    send_request(OP_FREE,  16'hFFFF,  8'd200);
    send_request(OP_FREE,  16'd0,     8'd2);
    send_request(OP_FREE,  16'd0,     8'd2);
    send_request(OP_ALLOC, 16'd257,   8'd0);
    send_request(OP_FREE,  16'd0,     8'd3);
    send_request(OP_FREE,  16'd0,     8'd1);
    send_request(OP_FREE,  16'd0,     8'd4);
    send_request(OP_FREE,  16'd0,     8'd5);
    send_request(OP_ALLOC, 16'd1024,  8'd0);
    send_request(OP_FREE,  16'd0,     8'd6);
    send_request(OP_ALLOC, 16'd2,     8'd0);
    send_request(OP_ALLOC, 16'd2,     8'd0);

    // Random phases over several memory sizes; order 15 saturates to ten.
    orders = '{4'd0, 4'd3, 4'd15, 4'd5, 4'd1, 4'd6, 4'd4, 4'd10, 4'd7, 4'd2};
    counts = '{ 120,  220,   120,  220,  120,  220,  220,   200,  220,  220};
    total  = 0;
    foreach (counts[p]) total += counts[p];
    done = 0;
    foreach (orders[p]) begin
      write_max_order(orders[p]);
      random_traffic(counts[p], total, done);
    end

    drain();
    repeat (40) @(posedge clk);
    $display("Checked %0d results over %0d memory sizes with stalls on both sides.",
             checked, orders.size() + 1);
    $display("Outcomes: %0d ok, %0d no space, %0d unknown id, %0d ids exhausted.",
             n_ok, n_nospace, n_unknown, n_idsgone);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("buddy_memory_allocator: match");
    end else begin
      $display("buddy_memory_allocator: mismatch");
    end
    $finish;
  end

endmodule
